### rtl/itad_pkg.sv
`timescale 1ns / 1ps
// Package for the integer-to-ASCII digit converter.
// Holds the request and response types, sizing constants and the digit-to-ASCII map.
package itad_pkg;

   // Width of the value field on the request port.
   localparam int ITAD_IN_BITS = 32;
   // Default width of the converted value.
   localparam int ITAD_VALUE_BITS = 32;
   // Width of one decimal or hexadecimal digit.
   localparam int ITAD_DIGIT_BITS = 4;
   // Width of an ASCII character on the response port.
   localparam int ITAD_CHAR_BITS = 7;

   // ASCII bases for the two digit ranges.
   localparam logic [ITAD_CHAR_BITS-1:0] ITAD_ASCII_ZERO = 7'd48;
   localparam logic [ITAD_CHAR_BITS-1:0] ITAD_ASCII_A_LESS_TEN = 7'd87;
   localparam logic [ITAD_DIGIT_BITS-1:0] ITAD_MAX_DEC_DIGIT = 4'd9;

   typedef struct packed {
      logic [ITAD_IN_BITS-1:0] value;
      logic                    hex_mode;
   } itad_req_type;

   typedef struct packed {
      logic [ITAD_CHAR_BITS-1:0] digit_char;
      logic                      last;
   } itad_rsp_type;

   // Map a digit 0..15 to '0'..'9' or 'a'..'f'.
   function automatic logic [ITAD_CHAR_BITS-1:0] itad_ascii(
      input logic [ITAD_DIGIT_BITS-1:0] digit
   );
      logic [ITAD_CHAR_BITS-1:0] wide_digit;
      wide_digit = {{(ITAD_CHAR_BITS-ITAD_DIGIT_BITS){1'b0}}, digit};
      if (digit <= ITAD_MAX_DEC_DIGIT) begin
         return ITAD_ASCII_ZERO + wide_digit;
      end
      return ITAD_ASCII_A_LESS_TEN + wide_digit;
   endfunction

endpackage

### rtl/int_to_ascii_digits.sv
`timescale 1ns / 1ps
// Integer-to-ASCII digit converter, top level.
// Depends on itad_pkg for the request and response types and the ASCII map.
//
// Usage: drive req_data and raise start; the request is taken at a clock edge
// where start is high and busy is low. The block then emits one response per
// digit on rsp_data, most significant digit first, each for exactly one cycle
// with rsp_strobe high. rsp_data.last marks the final digit. Zero gives one
// digit '0'. Leading zeros are dropped.
//
// Timing: the value is shifted in one bit per cycle through a double-dabble
// BCD register (hex mode skips the add-3 correction), then the digit register
// is shifted out one digit per cycle. busy is high from the accepted request
// until the last digit leaves the register, and responses lag their digit by
// one register stage. A new request may be taken in the cycle the last
// response is shown.
//
// Reset (synchronous, active high) returns the block to idle and drops any
// request in progress. The receiver cannot stall; responses are never held.
module int_to_ascii_digits
   import itad_pkg::*;
#(
   parameter int VALUE_BITS = ITAD_VALUE_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  itad_req_type req_data,
   output logic         rsp_strobe,
   output itad_rsp_type rsp_data
);

   // Decimal digit slots: floor(VALUE_BITS * log10(2)) + 1.
   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_BITS = NUM_DIGITS * ITAD_DIGIT_BITS;
   localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
   localparam int DIG_CNT_BITS = $clog2(NUM_DIGITS);
   localparam logic [BIT_CNT_BITS-1:0] BIT_CNT_LAST = BIT_CNT_BITS'(VALUE_BITS - 1);
   localparam logic [DIG_CNT_BITS-1:0] DIG_CNT_LAST = DIG_CNT_BITS'(NUM_DIGITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [VALUE_BITS-1:0]   value_ff;
   logic                    hex_ff;
   logic [BCD_BITS-1:0]     bcd_ff;
   logic [BIT_CNT_BITS-1:0] bit_cnt_ff;
   logic [DIG_CNT_BITS-1:0] dig_cnt_ff;
   logic                    started_ff;
   logic                    rsp_strobe_ff;
   itad_rsp_type            rsp_data_ff;

   logic [BCD_BITS-1:0]        bcd_adj_in;
   logic [ITAD_DIGIT_BITS-1:0] top_digit;
   logic                       emit_last;
   logic                       emit_show;

   // Add-3 correction on every BCD digit of 5 or more; hex mode passes through.
   always_comb begin
      bcd_adj_in = bcd_ff;
      if (!hex_ff) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_ff[i*ITAD_DIGIT_BITS +: ITAD_DIGIT_BITS] >= 4'd5) begin
               bcd_adj_in[i*ITAD_DIGIT_BITS +: ITAD_DIGIT_BITS] =
                  bcd_ff[i*ITAD_DIGIT_BITS +: ITAD_DIGIT_BITS] + 4'd3;
            end
         end
      end
   end

   // The digit leaving the top of the register, and whether it is shown.
   assign top_digit = bcd_ff[BCD_BITS-1 -: ITAD_DIGIT_BITS];
   assign emit_last = (dig_cnt_ff == DIG_CNT_LAST);
   assign emit_show = started_ff || (top_digit != '0) || emit_last;

   // Sequencer: load, shift the value in bit by bit, shift digits out.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         started_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         bit_cnt_ff    <= '0;
         dig_cnt_ff    <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  value_ff   <= VALUE_BITS'(req_data.value);
                  hex_ff     <= req_data.hex_mode;
                  bcd_ff     <= '0;
                  bit_cnt_ff <= BIT_CNT_LAST;
                  state_ff   <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               bcd_ff   <= {bcd_adj_in[BCD_BITS-2:0], value_ff[VALUE_BITS-1]};
               value_ff <= value_ff << 1;
               if (bit_cnt_ff == '0) begin
                  dig_cnt_ff <= '0;
                  started_ff <= 1'b0;
                  state_ff   <= ST_EMIT;
               end else begin
                  bit_cnt_ff <= bit_cnt_ff - 1'b1;
               end
            end
            ST_EMIT: begin
               bcd_ff        <= bcd_ff << ITAD_DIGIT_BITS;
               started_ff    <= emit_show;
               rsp_strobe_ff <= emit_show;
               rsp_data_ff   <= '{digit_char: itad_ascii(top_digit), last: emit_last};
               if (emit_last) begin
                  state_ff <= ST_IDLE;
               end else begin
                  dig_cnt_ff <= dig_cnt_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### sim/int_to_ascii_digits_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the integer-to-ASCII digit converter.
// Depends on itad_pkg and int_to_ascii_digits; a digit scoreboard predicts every response.

module int_to_ascii_digits_tb
   import itad_pkg::*;
();

   localparam int VALUE_BITS = ITAD_VALUE_BITS;
   localparam int MAX_DIGITS = 20;
   localparam int RANDOM_PER_PHASE = 43;
   localparam int SETTLE_CYCLES = 50;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [ITAD_CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
   localparam logic [ITAD_CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;

   // Holds the digits still owed by the block and checks each response against them.
   class digit_scoreboard;
      itad_rsp_type expected_digits[$];
      int mismatch_count;
      int digits_checked;
      int dec_requests;
      int hex_requests;

      function new();
         mismatch_count = 0;
         digits_checked = 0;
         dec_requests = 0;
         hex_requests = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      // Work out the digits of an accepted request, most significant first.
      function void note_request(itad_req_type req);
         logic [63:0] remaining;
         logic [3:0] digs[MAX_DIGITS];
         logic [3:0] digit;
         int count;
         itad_rsp_type rsp;
         remaining = 64'(req.value);
         if (VALUE_BITS < 64) begin
            remaining = remaining & ((64'd1 << VALUE_BITS) - 64'd1);
         end
         count = 0;
         if (req.hex_mode) hex_requests++;
         else dec_requests++;
         do begin
            if (req.hex_mode) begin
               digit = remaining[3:0];
               remaining = remaining >> 4;
            end else begin
               digit = 4'(remaining % 64'd10);
               remaining = remaining / 64'd10;
            end
            if (count < MAX_DIGITS) begin
               digs[count] = digit;
               count++;
            end
         end while (remaining != 64'd0);
         for (int k = count - 1; k >= 0; k--) begin
            if (digs[k] <= 4'd9) begin
               rsp.digit_char = CHAR_ZERO + 7'(digs[k]);
            end else begin
               rsp.digit_char = CHAR_LOWER_A + 7'(digs[k]) - 7'd10;
            end
            rsp.last = (k == 0);
            expected_digits.push_back(rsp);
         end
      endfunction

      // Compare one response with the oldest expected digit.
      task check_response(itad_rsp_type rsp);
         itad_rsp_type want;
         if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected response char=%0h last=%0b",
                                      rsp.digit_char, rsp.last));
            return;
         end
         want = expected_digits.pop_front();
         digits_checked++;
         if (rsp.digit_char !== want.digit_char) begin
            report_mismatch($sformatf("digit_char got %0h want %0h",
                                      rsp.digit_char, want.digit_char));
         end
         if (rsp.last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", rsp.last, want.last));
         end
      endtask

      function int pending();
         return expected_digits.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   itad_req_type req_data = '0;
   logic rsp_strobe;
   itad_rsp_type rsp_data;

   digit_scoreboard board;
   int sender_idle_pct = 0;
   int cycle_count = 0;

   int_to_ascii_digits dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watch both channels at every rising edge, seeing values from before the edge.
   always @(posedge clock) begin
      if (!reset && board != null) begin
         if (start && !busy) board.note_request(req_data);
         if (rsp_strobe) board.check_response(rsp_data);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d digits outstanding",
                  cycle_count, board.pending());
         $display("int_to_ascii_digits verification failed");
         $finish;
      end
   end

   // Present one request after a random idle stretch and hold it until taken.
   task send_request(input logic [31:0] value, input logic hex_mode);
      int gap;
      itad_req_type req;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.value = value;
      req.hex_mode = hex_mode;
      start <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending until every expected digit has come back. The first wait lets
   // the monitor note the request taken at the current edge.
   task wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task send_random_request();
      logic [31:0] value;
      case ($urandom_range(3))
         0: value = $urandom;
         1: value = $urandom >> $urandom_range(31);
         2: value = $urandom_range(20);
         default: value = 32'hffff_ffff - $urandom_range(3);
      endcase
      send_request(value, 1'($urandom_range(1)));
   endtask

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: zero, single digits, digit-count boundaries and extremes.
      sender_idle_pct = 13;
      send_request(32'd0, 1'b0);
      send_request(32'd0, 1'b1);
      send_request(32'd7, 1'b0);
      send_request(32'd9, 1'b0);
      send_request(32'd10, 1'b0);
      send_request(32'd15, 1'b1);
      send_request(32'd16, 1'b1);
      send_request(32'd999_999_999, 1'b0);
      send_request(32'd1_000_000_000, 1'b0);
      send_request(32'd1_234_567_890, 1'b0);
      send_request(32'hffff_ffff, 1'b0);
      send_request(32'hffff_ffff, 1'b1);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h8000_0000, 1'b1);
      send_request(32'h0123_4567, 1'b1);
      send_request(32'h89ab_cdef, 1'b1);
      send_request(32'hdead_beef, 1'b1);
      send_request(32'h0fff_ffff, 1'b1);
      send_request(32'd100, 1'b0);
      send_request(32'd5, 1'b1);
      wait_drained();

      // Random requests under three sender idle settings, draining between them.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 49 : 0;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_request();
         wait_drained();
      end

      // Let the block settle so that any stray response is caught.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d decimal and %0d hexadecimal requests, %0d digits checked.",
               board.dec_requests, board.hex_requests, board.digits_checked);
      $display("Mismatches: %0d, digits still owed: %0d.",
               board.mismatch_count, board.pending());
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("int_to_ascii_digits verification clean");
      end else begin
         $display("int_to_ascii_digits verification failed");
      end
      $finish;
   end

endmodule
